// ===== hw/rtl/cnes_pkg.sv =====
// Shared types and constants of the coupled node Euler step block.
// No dependencies; imported by cnes_alu, cnes_div and the top level.
package cnes_pkg;

  // Fixed sizes of the node network
  localparam int unsigned NODE_W     = 8;
  localparam int unsigned NODES      = 256;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned MAX_DEGREE = 16;
  localparam int unsigned DEG_W      = 5;
  localparam int unsigned NBR_ADDR_W = NODE_W + SLOT_W;
  localparam int unsigned SUM_W      = 32 + SLOT_W + 1;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned STEPS_W    = 16;

  // Item actions
  typedef enum logic [2:0] {
    ACT_WR_VALUE = 3'd0,
    ACT_WR_NBR   = 3'd1,
    ACT_SET_DEG  = 3'd2,
    ACT_RUN      = 3'd3,
    ACT_RD_VALUE = 3'd4,
    ACT_SYNC     = 3'd5
  } action_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_COUPLING   = 3'd0,
    CFG_NODE_COUNT = 3'd1,
    CFG_GAIN_M     = 3'd2,
    CFG_ALPHA      = 3'd3,
    CFG_RHO_ONE    = 3'd4,
    CFG_RHO_TWO    = 3'd5,
    CFG_GAMMA      = 3'd6,
    CFG_TIME_STEP  = 3'd7
  } cfg_idx_e;

  // Sync check results
  typedef enum logic [1:0] {
    WELL_NONE = 2'd0,
    WELL_LOW  = 2'd1,
    WELL_HIGH = 2'd2
  } well_e;

  // Shared arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_ADD = 2'd1,
    ALU_SUB = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // Saturate a 64-bit signed value to 32 bits signed
  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic [31:0] r;
    if ($signed(v) > $signed(64'sh0000_0000_7FFF_FFFF)) begin
      r = 32'h7FFF_FFFF;
    end else if ($signed(v) < $signed(64'shFFFF_FFFF_8000_0000)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cnes_alu.sv =====
// Shared two-stage arithmetic unit: saturating Q-format multiply, add, subtract.
// Depends on cnes_pkg.
module cnes_alu import cnes_pkg::*; #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alu_req_t           req_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic [31:0]        res_o
);

  logic               v1_q, v2_q;
  alu_op_e            op1_q, op2_q;
  logic signed [31:0] a_q, b_q;
  logic signed [63:0] wide_d, wide_q, shifted;
  logic signed [63:0] prod;

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  // Form the full-width product or sum
  assign prod = a_q * b_q;

  always_comb begin
    case (op1_q)
      ALU_MUL: wide_d = prod;
      ALU_ADD: wide_d = {{32{a_q[31]}}, a_q} + {{32{b_q[31]}}, b_q};
      ALU_SUB: wide_d = {{32{a_q[31]}}, a_q} - {{32{b_q[31]}}, b_q};
      default: wide_d = '0;
    endcase
  end

  // Latch operands, then the raw result
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op1_q <= req_i.op;
      a_q   <= a_i;
      b_q   <= b_i;
    end
    op2_q  <= op1_q;
    wide_q <= wide_d;
  end

  // Products round toward minus infinity, then everything saturates
  assign shifted = (op2_q == ALU_MUL) ? (wide_q >>> FRAC_BITS) : wide_q;
  assign res_o   = sat32(shifted);
  assign done_o  = v2_q;

endmodule

// ===== hw/rtl/cnes_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, signed with saturation.
// Depends on cnes_pkg.
module cnes_div import cnes_pkg::*; #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [32+FRAC_BITS-1:0] dividend_i,
  input  logic signed [31:0]            divisor_i,
  output logic                          done_o,
  output logic [31:0]                   quot_o
);

  localparam int unsigned DVW   = 32 + FRAC_BITS;
  localparam int unsigned DCW   = $clog2(DVW);
  localparam logic [DVW-1:0] MAG_POS = DVW'(64'h0000_0000_7FFF_FFFF);
  localparam logic [DVW-1:0] MAG_NEG = DVW'(64'h0000_0000_8000_0000);
  localparam logic [DCW-1:0] LAST   = DCW'(DVW - 1);

  logic           busy_q, done_q, neg_q;
  logic [DCW-1:0] cnt_q;
  logic [31:0]    dvs_q, rem_q;
  logic [DVW-1:0] quo_q, neg_mag;
  logic [32:0]    sh, diff;
  logic           ge;

  // One trial subtraction per cycle
  assign sh   = {rem_q, quo_q[DVW-1]};
  assign diff = sh - {1'b0, dvs_q};
  assign ge   = (sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Take magnitudes at start, then shift quotient bits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DVW-1] ^ divisor_i[31];
      quo_q <= dividend_i[DVW-1] ? (DVW'(0) - dividend_i) : dividend_i;
      dvs_q <= divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : sh[31:0];
      quo_q <= {quo_q[DVW-2:0], ge};
    end
  end

  // Apply sign and saturate
  assign neg_mag = DVW'(0) - quo_q;

  always_comb begin
    if (neg_q) begin
      quot_o = (quo_q > MAG_NEG) ? 32'h8000_0000 : neg_mag[31:0];
    end else begin
      quot_o = (quo_q > MAG_POS) ? 32'h7FFF_FFFF : quo_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== hw/rtl/coupled_node_euler_step.sv =====
// Coupled node Euler step: node value, neighbor and degree stores with a
// sequencer that drives one shared arithmetic unit and one serial divider.
// Depends on cnes_pkg, cnes_alu and cnes_div.
//
// Write value, write neighbor, set degree and unknown actions go straight to the
// done state; a read passes through its read state first. A sync check visits
// the active nodes one by one. A run item handles one node at a time. Every
// multiply, add or subtract goes through the shared unit, and every division
// through the serial divider. Per step and per node the sequencer works out the
// self term and stores the rate, reads each neighbor and divides for the mean
// when the node has neighbors, then updates every value in a second pass. The
// block takes no new item until the whole run is done.
module coupled_node_euler_step import cnes_pkg::*; #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [7:0]         node_i,
  input  logic [3:0]         slot_i,
  input  logic [7:0]         neighbor_i,
  input  logic [4:0]         degree_i,
  input  logic signed [31:0] value_i,
  input  logic [15:0]        steps_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] node_out_o,
  output logic [1:0]         well_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned DVW  = 32 + FRAC_BITS;
  localparam int unsigned ST_W = 36;
  localparam logic [63:0] ONE_W   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] ALPHA_W = 64'd11 << FRAC_BITS;
  localparam logic [63:0] RHO1_W  = 64'd2 << FRAC_BITS;
  localparam logic [63:0] RHO2_W  = ((64'd8 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] GAMMA_W = ((64'd5215 << FRAC_BITS) + 64'd500) / 64'd1000;
  localparam logic [63:0] DT_W    = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] MID_W   = ((64'd77 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic signed [31:0] ONE = ONE_W[31:0];
  localparam logic signed [31:0] MID = MID_W[31:0];

  typedef enum logic [ST_W-1:0] {
    S_IDLE = ST_W'(1) << 0,  S_DONE = ST_W'(1) << 1,  S_RDV  = ST_W'(1) << 2,
    S_LDX  = ST_W'(1) << 3,  S_GETX = ST_W'(1) << 4,  S_X2   = ST_W'(1) << 5,
    S_X4   = ST_W'(1) << 6,  S_X6   = ST_W'(1) << 7,  S_AR   = ST_W'(1) << 8,
    S_T1   = ST_W'(1) << 9,  S_T2   = ST_W'(1) << 10, S_RR   = ST_W'(1) << 11,
    S_T3   = ST_W'(1) << 12, S_BASE = ST_W'(1) << 13, S_NUM  = ST_W'(1) << 14,
    S_DSUM = ST_W'(1) << 15, S_DEN  = ST_W'(1) << 16, S_DIVQ = ST_W'(1) << 17,
    S_GM   = ST_W'(1) << 18, S_GX   = ST_W'(1) << 19, S_DSUB = ST_W'(1) << 20,
    S_NBA  = ST_W'(1) << 21, S_NBR  = ST_W'(1) << 22, S_ACC  = ST_W'(1) << 23,
    S_MEAN = ST_W'(1) << 24, S_DIFF = ST_W'(1) << 25, S_CD   = ST_W'(1) << 26,
    S_DADD = ST_W'(1) << 27, S_WD   = ST_W'(1) << 28, S_LD2  = ST_W'(1) << 29,
    S_UMUL = ST_W'(1) << 30, S_UADD = ST_W'(1) << 31, S_WV   = ST_W'(1) << 32,
    S_SYA  = ST_W'(1) << 33, S_SYF  = ST_W'(1) << 34, S_SYC  = ST_W'(1) << 35
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic signed [31:0] coupling_q, gain_q, alpha_q, rho1_q, rho2_q, gamma_q;
  logic [CNT_W-1:0]   node_count_q;
  logic [30:0]        dt_q;

  // Sequencer counters and result staging
  logic [NODE_W-1:0]  i_q, n_last;
  logic [DEG_W-1:0]   j_q;
  logic [STEPS_W-1:0] steps_q;
  logic               pend_q;
  logic               out_valid_q;
  logic signed [31:0] out_node_q, res_node_q;
  logic [1:0]         out_well_q, res_well_q;

  // Per-node working registers
  logic signed [31:0] x_q, x2_q, x4_q, x6_q, t_q, t1_q, t2_q, t3_q;
  logic signed [31:0] base_q, num_q, den_q, q_q, a_q, b_q, d_q, mean_q;
  logic [DEG_W-1:0]   deg_q;
  logic [SUM_W-1:0]   sum_q;
  logic               fpos_q, fneg_q;

  // Memories
  logic [31:0]       nv_mem [NODES];
  logic [31:0]       der_mem [NODES];
  logic [NODE_W-1:0] nbr_mem [NODES*MAX_DEGREE];
  logic [DEG_W-1:0]  deg_mem [NODES];
  logic [NODES-1:0]  deg_vld_q;

  logic [31:0]       nv_rdata_q, der_rdata_q;
  logic [NODE_W-1:0] nbr_rdata_q;
  logic [DEG_W-1:0]  deg_rdata_q;
  logic              deg_vld_rd_q;

  logic              nv_we;
  logic [NODE_W-1:0] nv_waddr, nv_raddr;
  logic [31:0]       nv_wdata;
  logic              in_fire, cfg_fire;
  action_e           act;

  // Shared units
  alu_req_t           alu_req;
  logic signed [31:0] alu_a, alu_b;
  logic               alu_done;
  logic [31:0]        alu_res;
  logic               div_start, div_done;
  logic signed [DVW-1:0] div_dvd;
  logic signed [31:0] div_dvs;
  logic [31:0]        div_quot;

  logic               cur_pos, cur_neg;
  logic [1:0]         well_first, well_cur;
  logic [DEG_W-1:0]   deg_sat;
  logic [CNT_W-1:0]   cnt_m1;

  cnes_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  cnes_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign act         = action_e'(action_i);
  assign deg_sat     = (degree_i > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_i;

  // Last active node index
  assign cnt_m1 = node_count_q - 1'b1;
  always_comb begin
    if (node_count_q == '0) begin
      n_last = '0;
    end else if (node_count_q > CNT_W'(NODES)) begin
      n_last = NODE_W'(NODES - 1);
    end else begin
      n_last = cnt_m1[NODE_W-1:0];
    end
  end

  // Sync comparisons against mid well
  assign cur_pos    = $signed(nv_rdata_q) > MID;
  assign cur_neg    = $signed(nv_rdata_q) < MID;
  assign well_first = fpos_q ? WELL_HIGH : (fneg_q ? WELL_LOW : WELL_NONE);
  assign well_cur   = cur_pos ? WELL_HIGH : (cur_neg ? WELL_LOW : WELL_NONE);

  // Sequencer: next state and unit requests
  always_comb begin
    state_d       = state_q;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (act)
            ACT_RUN:      state_d = (steps_i == '0) ? S_DONE : S_LDX;
            ACT_RD_VALUE: state_d = S_RDV;
            ACT_SYNC:     state_d = S_SYA;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      S_RDV:  state_d = S_DONE;
      S_LDX:  state_d = S_GETX;
      S_GETX: state_d = S_X2;
      S_X2: begin
        alu_req.start = !pend_q; alu_a = x_q; alu_b = x_q;
        if (alu_done) state_d = S_X4;
      end
      S_X4: begin
        alu_req.start = !pend_q; alu_a = x2_q; alu_b = x2_q;
        if (alu_done) state_d = S_X6;
      end
      S_X6: begin
        alu_req.start = !pend_q; alu_a = x4_q; alu_b = x2_q;
        if (alu_done) state_d = S_AR;
      end
      S_AR: begin
        alu_req.start = !pend_q; alu_a = alpha_q; alu_b = rho1_q;
        if (alu_done) state_d = S_T1;
      end
      S_T1: begin
        alu_req.start = !pend_q; alu_a = t_q; alu_b = x4_q;
        if (alu_done) state_d = S_T2;
      end
      S_T2: begin
        alu_req.start = !pend_q; alu_a = rho1_q; alu_b = x4_q;
        if (alu_done) state_d = S_RR;
      end
      S_RR: begin
        alu_req.start = !pend_q; alu_a = rho1_q; alu_b = rho2_q;
        if (alu_done) state_d = S_T3;
      end
      S_T3: begin
        alu_req.start = !pend_q; alu_a = t_q; alu_b = x6_q;
        if (alu_done) state_d = S_BASE;
      end
      S_BASE: begin
        alu_req.start = !pend_q; alu_req.op = ALU_ADD; alu_a = ONE; alu_b = x2_q;
        if (alu_done) state_d = S_NUM;
      end
      S_NUM: begin
        alu_req.start = !pend_q; alu_req.op = ALU_ADD; alu_a = base_q; alu_b = t1_q;
        if (alu_done) state_d = S_DSUM;
      end
      S_DSUM: begin
        alu_req.start = !pend_q; alu_req.op = ALU_ADD; alu_a = t2_q; alu_b = t3_q;
        if (alu_done) state_d = S_DEN;
      end
      S_DEN: begin
        alu_req.start = !pend_q; alu_req.op = ALU_ADD; alu_a = base_q; alu_b = t_q;
        if (alu_done) state_d = S_DIVQ;
      end
      S_DIVQ: begin
        div_dvd = {num_q, {FRAC_BITS{1'b0}}};
        div_dvs = den_q;
        if (den_q == '0) begin
          state_d = S_GM;
        end else begin
          div_start = !pend_q;
          if (div_done) state_d = S_GM;
        end
      end
      S_GM: begin
        alu_req.start = !pend_q; alu_a = gain_q; alu_b = q_q;
        if (alu_done) state_d = S_GX;
      end
      S_GX: begin
        alu_req.start = !pend_q; alu_a = gamma_q; alu_b = x_q;
        if (alu_done) state_d = S_DSUB;
      end
      S_DSUB: begin
        alu_req.start = !pend_q; alu_req.op = ALU_SUB; alu_a = a_q; alu_b = b_q;
        if (alu_done) state_d = (deg_q == '0) ? S_WD : S_NBA;
      end
      S_NBA: state_d = S_NBR;
      S_NBR: state_d = S_ACC;
      S_ACC: state_d = (j_q + 1'b1 == deg_q) ? S_MEAN : S_NBA;
      S_MEAN: begin
        div_dvd   = {{(DVW-SUM_W){sum_q[SUM_W-1]}}, sum_q};
        div_dvs   = 32'(deg_q);
        div_start = !pend_q;
        if (div_done) state_d = S_DIFF;
      end
      S_DIFF: begin
        alu_req.start = !pend_q; alu_req.op = ALU_SUB; alu_a = mean_q; alu_b = x_q;
        if (alu_done) state_d = S_CD;
      end
      S_CD: begin
        alu_req.start = !pend_q; alu_a = coupling_q; alu_b = t_q;
        if (alu_done) state_d = S_DADD;
      end
      S_DADD: begin
        alu_req.start = !pend_q; alu_req.op = ALU_ADD; alu_a = d_q; alu_b = t_q;
        if (alu_done) state_d = S_WD;
      end
      S_WD:  state_d = (i_q == n_last) ? S_LD2 : S_LDX;
      S_LD2: state_d = S_UMUL;
      S_UMUL: begin
        alu_req.start = !pend_q; alu_a = der_rdata_q; alu_b = {1'b0, dt_q};
        if (alu_done) state_d = S_UADD;
      end
      S_UADD: begin
        alu_req.start = !pend_q; alu_req.op = ALU_ADD; alu_a = nv_rdata_q; alu_b = t_q;
        if (alu_done) state_d = S_WV;
      end
      S_WV: begin
        if (i_q != n_last) begin
          state_d = S_LD2;
        end else begin
          state_d = (steps_q == STEPS_W'(1)) ? S_DONE : S_LDX;
        end
      end
      S_SYA: state_d = (i_q == '0) ? S_SYF : S_SYC;
      S_SYF: state_d = (n_last == '0) ? S_DONE : S_SYA;
      S_SYC: begin
        if ((cur_pos && fneg_q) || (cur_neg && fpos_q) || (i_q == n_last)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SYA;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Advance control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (alu_req.start || div_start) begin
        pend_q <= 1'b1;
      end else if (alu_done || div_done) begin
        pend_q <= 1'b0;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        i_q     <= '0;
        steps_q <= steps_i;
      end
      if (state_q == S_DSUB && alu_done) j_q <= '0;
      if (state_q == S_ACC) j_q <= j_q + 1'b1;
      if (state_q == S_WD) i_q <= (i_q == n_last) ? '0 : i_q + 1'b1;
      if (state_q == S_WV) begin
        i_q <= (i_q == n_last) ? '0 : i_q + 1'b1;
        if (i_q == n_last) steps_q <= steps_q - 1'b1;
      end
      if (state_q == S_SYF || state_q == S_SYC) i_q <= i_q + 1'b1;
    end
  end

  // Capture unit results and per-item results
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_node_q <= '0;
      res_well_q <= WELL_NONE;
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_node_q <= res_node_q;
      out_well_q <= res_well_q;
    end
    case (state_q)
      S_RDV: res_node_q <= nv_rdata_q;
      S_GETX: begin
        x_q   <= nv_rdata_q;
        deg_q <= deg_vld_rd_q ? deg_rdata_q : '0;
      end
      S_DIVQ: begin
        if (den_q == '0) begin
          q_q <= (num_q > 0) ? 32'sh7FFF_FFFF : ((num_q < 0) ? 32'sh8000_0000 : '0);
        end else if (div_done) begin
          q_q <= div_quot;
        end
      end
      S_MEAN: if (div_done) mean_q <= div_quot;
      S_ACC:  sum_q <= sum_q + {{(SUM_W-32){nv_rdata_q[31]}}, nv_rdata_q};
      S_SYF: begin
        fpos_q <= cur_pos;
        fneg_q <= cur_neg;
        if (n_last == '0) res_well_q <= well_cur;
      end
      S_SYC: begin
        if ((cur_pos && fneg_q) || (cur_neg && fpos_q)) begin
          res_well_q <= WELL_NONE;
        end else if (i_q == n_last) begin
          res_well_q <= well_first;
        end
      end
      default: ;
    endcase
    if (alu_done) begin
      case (state_q)
        S_X2:   x2_q   <= alu_res;
        S_X4:   x4_q   <= alu_res;
        S_X6:   x6_q   <= alu_res;
        S_AR:   t_q    <= alu_res;
        S_T1:   t1_q   <= alu_res;
        S_T2:   t2_q   <= alu_res;
        S_RR:   t_q    <= alu_res;
        S_T3:   t3_q   <= alu_res;
        S_BASE: base_q <= alu_res;
        S_NUM:  num_q  <= alu_res;
        S_DSUM: t_q    <= alu_res;
        S_DEN:  den_q  <= alu_res;
        S_GM:   a_q    <= alu_res;
        S_GX:   b_q    <= alu_res;
        S_DSUB: begin
          d_q   <= alu_res;
          sum_q <= '0;
        end
        S_DIFF: t_q    <= alu_res;
        S_CD:   t_q    <= alu_res;
        S_DADD: d_q    <= alu_res;
        S_UMUL: t_q    <= alu_res;
        default: ;
      endcase
    end
  end

  // Node value store: one write port, one registered read port
  assign nv_we    = (in_fire && act == ACT_WR_VALUE) || (state_q == S_UADD && alu_done);
  assign nv_waddr = in_fire ? node_i : i_q;
  assign nv_wdata = in_fire ? value_i : alu_res;

  always_comb begin
    if (state_q == S_IDLE) begin
      nv_raddr = node_i;
    end else if (state_q == S_NBR) begin
      nv_raddr = nbr_rdata_q;
    end else begin
      nv_raddr = i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nv_we) nv_mem[nv_waddr] <= nv_wdata;
    nv_rdata_q <= nv_mem[nv_raddr];
  end

  // Derivative store
  always_ff @(posedge clk_i) begin
    if (state_q == S_WD) der_mem[i_q] <= d_q;
    der_rdata_q <= der_mem[i_q];
  end

  // Neighbor store
  always_ff @(posedge clk_i) begin
    if (in_fire && act == ACT_WR_NBR) nbr_mem[{node_i, slot_i}] <= neighbor_i;
    nbr_rdata_q <= nbr_mem[{i_q, j_q[SLOT_W-1:0]}];
  end

  // Degree store; an entry never set reads as zero
  always_ff @(posedge clk_i) begin
    if (in_fire && act == ACT_SET_DEG) deg_mem[node_i] <= deg_sat;
    deg_rdata_q  <= deg_mem[i_q];
    deg_vld_rd_q <= deg_vld_q[i_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_vld_q <= '0;
    end else if (in_fire && act == ACT_SET_DEG) begin
      deg_vld_q[node_i] <= 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_q   <= '0;
      node_count_q <= CNT_W'(1);
      gain_q       <= ONE_W[31:0];
      alpha_q      <= ALPHA_W[31:0];
      rho1_q       <= RHO1_W[31:0];
      rho2_q       <= RHO2_W[31:0];
      gamma_q      <= GAMMA_W[31:0];
      dt_q         <= DT_W[30:0];
    end else if (cfg_fire) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COUPLING:   coupling_q   <= cfg_data_i;
        CFG_NODE_COUNT: node_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_GAIN_M:     gain_q       <= cfg_data_i;
        CFG_ALPHA:      alpha_q      <= cfg_data_i;
        CFG_RHO_ONE:    rho1_q       <= cfg_data_i;
        CFG_RHO_TWO:    rho2_q       <= cfg_data_i;
        CFG_GAMMA:      gamma_q      <= cfg_data_i;
        CFG_TIME_STEP:  dt_q         <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign node_out_o  = out_node_q;
  assign well_o      = out_well_q;

  // Checks on the sequencer
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVQ && div_start) |-> (den_q != '0))
    else $error("quotient divider started with zero denominator");

  a_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LDX) |-> (i_q <= n_last))
    else $error("node index past active node count");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NBA) |-> (j_q < deg_q))
    else $error("neighbor slot past node degree");

  a_alu_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> pend_q)
    else $error("unit result without a pending request");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside of done state");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for coupled_node_euler_step: random and directed item beats.
// Depends on cnes_pkg and the coupled_node_euler_step RTL; the predictor lives here.
module testbench;
  import cnes_pkg::*;

  localparam int FRAC = 24;
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam logic [31:0] Q_ONE = 32'h0100_0000;

  typedef struct {
    logic [2:0]         action;
    logic [7:0]         node;
    logic [3:0]         slot;
    logic [7:0]         neighbor;
    logic [4:0]         degree;
    logic signed [31:0] value;
    logic [15:0]        steps;
  } item_t;

  typedef struct {
    logic signed [31:0] node_out;
    logic [1:0]         well;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // DUT-facing signals
  logic               in_valid = 1'b0;
  logic               in_ready;
  item_t              cur = '{3'd0, 8'd0, 4'd0, 8'd0, 5'd0, 32'sd0, 16'd0};
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] node_out;
  logic [1:0]         well;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 3'd0;
  logic [31:0]        cfg_data = 32'd0;

  // Stimulus and expectation stores
  item_t   item_q[$];
  result_t expected_q[$];
  bit      written[NODES];
  int      written_list[$];

  // Predictor state
  logic signed [31:0] p_value[NODES];
  logic signed [31:0] p_rate[NODES];
  logic [7:0]         p_nbr[NODES*MAX_DEGREE];
  logic [4:0]         p_deg[NODES];
  logic signed [31:0] c_coupling, c_gain, c_alpha, c_rho1, c_rho2, c_gamma;
  logic [8:0]         c_count;
  logic [30:0]        c_dt;

  int  errors = 0;
  int  n_beats = 0, n_runs = 0, n_syncs = 0, n_checked = 0;
  int  cycles = 0;
  int  snd_idle = 0, rcv_idle = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  logic in_taken = 1'b0;

  coupled_node_euler_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (cur.action),
    .node_i      (cur.node),
    .slot_i      (cur.slot),
    .neighbor_i  (cur.neighbor),
    .degree_i    (cur.degree),
    .value_i     (cur.value),
    .steps_i     (cur.steps),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .node_out_o  (node_out),
    .well_o      (well),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Fixed-point helpers of the predictor
  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> FRAC);
  endfunction

  function automatic logic signed [31:0] fx_div(longint n, longint d);
    if (d == 0) return (n > 0) ? 32'sh7FFF_FFFF : ((n < 0) ? 32'sh8000_0000 : 32'sd0);
    return clamp32((n <<< FRAC) / d);
  endfunction

  function automatic int active_nodes();
    if (c_count == 0) return 1;
    return (c_count > NODES) ? NODES : int'(c_count);
  endfunction

  // Switch self term: m*N/D - gamma*x
  function automatic logic signed [31:0] switch_rate(logic signed [31:0] x);
    logic signed [31:0] x2, x4, x6, base, num, den;
    x2 = fx_mul(x, x);
    x4 = fx_mul(x2, x2);
    x6 = fx_mul(x4, x2);
    base = clamp32(longint'(Q_ONE) + x2);
    num = clamp32(longint'(base) + fx_mul(fx_mul(c_alpha, c_rho1), x4));
    den = clamp32(longint'(base) + clamp32(longint'(fx_mul(c_rho1, x4))
          + fx_mul(fx_mul(c_rho1, c_rho2), x6)));
    return clamp32(longint'(fx_mul(c_gain, fx_div(num, den))) - fx_mul(c_gamma, x));
  endfunction

  // One Euler step: all rates from old values, then update
  function automatic void advance_network();
    int n;
    longint sum;
    logic signed [31:0] d, x;
    n = active_nodes();
    for (int i = 0; i < n; i++) begin
      x = p_value[i];
      d = switch_rate(x);
      if (p_deg[i] > 0) begin
        sum = 0;
        for (int j = 0; j < p_deg[i]; j++) sum += p_value[p_nbr[i*MAX_DEGREE + j]];
        d = clamp32(longint'(d) + fx_mul(c_coupling,
            clamp32(longint'(clamp32(sum / longint'(p_deg[i]))) - x)));
      end
      p_rate[i] = d;
    end
    for (int i = 0; i < n; i++)
      p_value[i] = clamp32(longint'(p_value[i]) + fx_mul(p_rate[i], longint'(c_dt)));
  endfunction

  function automatic logic [1:0] well_of_network();
    longint mid, first, d;
    int n;
    mid = (longint'(77) * (longint'(1) <<< FRAC) + 50) / 100;
    n = active_nodes();
    first = longint'(p_value[0]) - mid;
    for (int i = 1; i < n; i++) begin
      d = longint'(p_value[i]) - mid;
      if ((d > 0 && first < 0) || (d < 0 && first > 0)) return WELL_NONE;
    end
    if (first > 0) return WELL_HIGH;
    if (first < 0) return WELL_LOW;
    return WELL_NONE;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      CFG_COUPLING:   c_coupling = data;
      CFG_NODE_COUNT: c_count = data[8:0];
      CFG_GAIN_M:     c_gain = data;
      CFG_ALPHA:      c_alpha = data;
      CFG_RHO_ONE:    c_rho1 = data;
      CFG_RHO_TWO:    c_rho2 = data;
      CFG_GAMMA:      c_gamma = data;
      default:        c_dt = data[30:0];
    endcase
  endfunction

  // Work out the result of one accepted item beat
  function automatic result_t predict_item(item_t it);
    result_t r;
    r.node_out = '0;
    r.well = WELL_NONE;
    case (it.action)
      ACT_WR_VALUE: p_value[it.node] = it.value;
      ACT_WR_NBR:   p_nbr[{it.node, it.slot}] = it.neighbor;
      ACT_SET_DEG:  p_deg[it.node] = (it.degree > 5'(MAX_DEGREE)) ? 5'(MAX_DEGREE)
                                                                   : it.degree;
      ACT_RUN: begin
        for (int k = 0; k < it.steps; k++) advance_network();
        n_runs++;
      end
      ACT_RD_VALUE: r.node_out = p_value[it.node];
      ACT_SYNC: begin
        r.well = well_of_network();
        n_syncs++;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Queue one item; unused fields carry random bits
  function automatic void push_item(logic [2:0] a, int node, int slot, int nb, int deg,
                                    logic [31:0] val, int steps);
    item_t it;
    it.action = a;
    it.node = 8'(node);
    it.slot = (slot < 0) ? 4'($urandom_range(15)) : 4'(slot);
    it.neighbor = (nb < 0) ? 8'($urandom_range(255)) : 8'(nb);
    it.degree = (deg < 0) ? 5'($urandom_range(31)) : 5'(deg);
    it.value = val;
    it.steps = (steps < 0) ? 16'($urandom_range(65535)) : 16'(steps);
    if (a == ACT_WR_VALUE && !written[node]) begin
      written[node] = 1'b1;
      written_list.push_back(node);
    end
    item_q.push_back(it);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return $urandom_range(32'h0300_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic int pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  // Fill the neighbor slots the degree uses, then set the degree
  function automatic void link_node(int node, int deg);
    for (int s = 0; s < deg && s < MAX_DEGREE; s++)
      push_item(ACT_WR_NBR, node, s, pick_written(), -1, $urandom(), -1);
    push_item(ACT_SET_DEG, node, -1, -1, deg, $urandom(), -1);
  endfunction

  function automatic void write_missing(int n);
    for (int i = 0; i < n; i++)
      if (!written[i]) push_item(ACT_WR_VALUE, i, -1, -1, -1, pick_value(), -1);
  endfunction

  function automatic void add_random(int count, int max_steps);
    int roll, deg;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        push_item(ACT_WR_VALUE, $urandom_range(255), -1, -1, -1, pick_value(), -1);
      end else if (roll < 45) begin
        push_item(ACT_RD_VALUE, pick_written(), -1, -1, -1, $urandom(), -1);
      end else if (roll < 55) begin
        push_item(ACT_SYNC, $urandom_range(255), -1, -1, -1, $urandom(), -1);
      end else if (roll < 68) begin
        deg = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(4);
        link_node($urandom_range(255), deg);
      end else if (roll < 78) begin
        push_item(ACT_WR_NBR, $urandom_range(255), -1, pick_written(), -1, $urandom(), -1);
      end else if (roll < 95) begin
        push_item(ACT_RUN, $urandom_range(255), -1, -1, -1, $urandom(),
                  $urandom_range(max_steps));
      end else begin
        push_item($urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B, $urandom_range(255),
                  -1, -1, -1, $urandom(), -1);
      end
    end
  endfunction

  // Wait until every queued beat has been answered
  task automatic drain_network();
    do @(posedge clk_i);
    while (item_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i);
    while (!(cfg_valid && cfg_ready));
    apply_cfg(idx, data);
  endtask

  task automatic cfg_release();
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Sender: hold the beat until taken, else offer the next one or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (item_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
      cur <= item_q.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni && ($urandom_range(99) >= rcv_idle);
    end
  end

  // Monitor: predict accepted items, check returned results
  always @(posedge clk_i) begin
    result_t exp_r;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("DONE: errors detected");
      $finish;
    end
    in_taken <= in_valid && in_ready;
    if (rst_ni && in_valid && in_ready) begin
      expected_q.push_back(predict_item(cur));
      n_beats++;
    end
    if (rst_ni && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result node_out=%0d well=%0d", $time, node_out, well);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        n_checked++;
        if (node_out !== exp_r.node_out) begin
          $display("%0t: node_out expected %0d actual %0d", $time, exp_r.node_out, node_out);
          errors++;
        end
        if (well !== exp_r.well) begin
          $display("%0t: well expected %0d actual %0d", $time, exp_r.well, well);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [31:0] mid;
    mid = 32'd12918456;
    c_coupling = 0;
    c_count = 1;
    c_gain = 32'sd16777216;
    c_alpha = 32'sd184549376;
    c_rho1 = 32'sd33554432;
    c_rho2 = 32'sd1342177;
    c_gamma = 32'sd87493181;
    c_dt = 31'd167772;
    for (int i = 0; i < NODES; i++) begin
      p_value[i] = '0;
      p_rate[i] = '0;
      p_deg[i] = '0;
      written[i] = 1'b0;
    end
    for (int i = 0; i < NODES*MAX_DEGREE; i++) p_nbr[i] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every action, mid-well and degree corner cases
    snd_idle = 17;
    rcv_idle = 79;
    push_item(ACT_WR_VALUE, 0, -1, -1, -1, 32'h7FFF_FFFF, -1);
    push_item(ACT_WR_VALUE, 1, -1, -1, -1, 32'h8000_0000, -1);
    push_item(ACT_WR_VALUE, 255, -1, -1, -1, 32'h0000_0000, -1);
    push_item(ACT_WR_VALUE, 2, -1, -1, -1, mid, -1);
    push_item(ACT_RD_VALUE, 0, -1, -1, -1, 0, -1);
    push_item(ACT_RD_VALUE, 1, -1, -1, -1, 0, -1);
    push_item(ACT_RD_VALUE, 255, -1, -1, -1, 0, -1);
    push_item(ACT_SYNC, 0, -1, -1, -1, 0, -1);
    push_item(ACT_SPARE_A, 0, -1, -1, -1, 32'hFFFF_FFFF, -1);
    push_item(ACT_SPARE_B, 255, -1, -1, -1, 32'hFFFF_FFFF, -1);
    push_item(ACT_WR_NBR, 0, 0, 1, -1, 0, -1);
    push_item(ACT_WR_NBR, 0, 1, 255, -1, 0, -1);
    push_item(ACT_SET_DEG, 0, -1, -1, 2, 0, -1);
    push_item(ACT_SET_DEG, 3, -1, -1, 0, 0, -1);
    push_item(ACT_RUN, 0, -1, -1, -1, 0, 0);
    push_item(ACT_RUN, 0, -1, -1, -1, 0, 1);
    push_item(ACT_RD_VALUE, 0, -1, -1, -1, 0, -1);
    push_item(ACT_WR_VALUE, 0, -1, -1, -1, mid, -1);
    push_item(ACT_SYNC, 0, -1, -1, -1, 0, -1);
    push_item(ACT_WR_VALUE, 0, -1, -1, -1, 32'h0040_0000, -1);
    push_item(ACT_SYNC, 0, -1, -1, -1, 0, -1);
    push_item(ACT_SET_DEG, 0, -1, -1, 0, 0, -1);
    push_item(ACT_RUN, 0, -1, -1, -1, 0, 2);
    push_item(ACT_RD_VALUE, 0, -1, -1, -1, 0, -1);
    drain_network();

    // Four coupled nodes near the wells; slow receiver and one long hold-off
    cfg_write(CFG_COUPLING, Q_ONE);
    cfg_write(CFG_NODE_COUNT, 32'd4);
    cfg_release();
    snd_idle = 17;
    rcv_idle = 79;
    write_missing(4);
    link_node(1, 3);
    for (int i = 0; i < 6; i++)
      push_item(ACT_RD_VALUE, pick_written(), -1, -1, -1, $urandom(), -1);
    @(posedge clk_i);
    hold_req = 1'b1;
    add_random(15, 6);
    drain_network();

    // Sixteen-node network with wide random coefficients; slow sender
    cfg_write(CFG_NODE_COUNT, 32'd16);
    cfg_write(CFG_COUPLING, $urandom());
    cfg_write(CFG_GAIN_M, 32'h7FFF_FFFF);
    cfg_write(CFG_ALPHA, 32'h8000_0000);
    cfg_write(CFG_RHO_ONE, $urandom());
    cfg_write(CFG_RHO_TWO, 32'h0000_0000);
    cfg_write(CFG_GAMMA, $urandom());
    cfg_write(CFG_TIME_STEP, $urandom() | 32'h8000_0000);
    cfg_release();
    snd_idle = 79;
    rcv_idle = 17;
    write_missing(16);
    push_item(ACT_SYNC, 0, -1, -1, -1, 0, -1);
    add_random(8, 1);
    drain_network();

    // Saturating coefficients, count of zero taken as one; no idling
    cfg_write(CFG_NODE_COUNT, 32'd0);
    cfg_write(CFG_COUPLING, 32'h8000_0000);
    cfg_write(CFG_GAIN_M, 32'h8000_0000);
    cfg_write(CFG_ALPHA, 32'h7FFF_FFFF);
    cfg_write(CFG_RHO_ONE, 32'h7FFF_FFFF);
    cfg_write(CFG_RHO_TWO, 32'h8000_0000);
    cfg_write(CFG_GAMMA, 32'h7FFF_FFFF);
    cfg_write(CFG_TIME_STEP, 32'h7FFF_FFFF);
    cfg_release();
    snd_idle = 0;
    rcv_idle = 0;
    add_random(8, 8);
    drain_network();

    // Back to the default switch with eight coupled nodes
    cfg_write(CFG_NODE_COUNT, 32'd8);
    cfg_write(CFG_COUPLING, 32'h0080_0000);
    cfg_write(CFG_GAIN_M, Q_ONE);
    cfg_write(CFG_ALPHA, 32'd184549376);
    cfg_write(CFG_RHO_ONE, 32'd33554432);
    cfg_write(CFG_RHO_TWO, 32'd1342177);
    cfg_write(CFG_GAMMA, 32'd87493181);
    cfg_write(CFG_TIME_STEP, 32'd167772);
    cfg_release();
    add_random(10, 10);
    drain_network();

    $display("Covered %0d item beats: %0d runs, %0d sync checks, %0d results checked",
             n_beats, n_runs, n_syncs, n_checked);
    $display("Settings: default, four coupled nodes, sixteen nodes, saturating, eight nodes");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cnes_pkg.sv
hw/rtl/cnes_alu.sv
hw/rtl/cnes_div.sv
hw/rtl/coupled_node_euler_step.sv
dv/testbench.sv
